// File: sv/fcu_pkg.sv
// Shared constants, types and arithmetic helpers for the fly camera update unit.
`default_nettype none
package fcu_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int POS_FRAC_BITS   = 16;
  localparam int CORDIC_ITERS    = 16;
  localparam int ATAN_COUNT      = 24;

  localparam int ANG_SHIFT    = 30 - ANGLE_FRAC_BITS;
  localparam int LOOK_SHIFT   = 16 - ANGLE_FRAC_BITS;
  localparam int DISP_SHIFT   = 48 - POS_FRAC_BITS;
  localparam int SINGLE_SHIFT = 16;
  localparam int PROD_SHIFT   = 46;
  localparam int LEN_PRESHIFT = 16;
  localparam int DIR_SHIFT    = 28;
  localparam int S28_SPLIT    = 20;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint LIMIT_Q30   = 64'sd1667889383;
  localparam longint KGAIN_Q30   = 64'sd652032874;
  localparam longint ANG_PI      = (PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam longint ANG_LIMIT   = (LIMIT_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam int     ONE_Q14     = 16384;

  localparam int ANG_W  = 16;  // stored angle
  localparam int SUM_W  = 18;  // angle before wrap / clamp
  localparam int ZW     = 35;  // CORDIC residual angle, Q30
  localparam int XW     = 34;  // CORDIC x/y, Q30
  localparam int CIW    = $clog2(ATAN_COUNT);
  localparam int MW     = 33;  // multiplier operand
  localparam int PW     = 2 * MW;
  localparam int MVW    = 18;  // movement sum, signed Q3.14
  localparam int SSW    = 34;  // sum of squares
  localparam int SDW    = 48;  // shift-subtract accumulator
  localparam int SDCW   = $clog2(SDW / 2);
  localparam int LENW   = SDW / 2 + 1;
  localparam int DIRW   = 22;  // direction, Q20 plus sign
  localparam int S28W   = 2 * S28_SPLIT;
  localparam int POSW   = 32;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRINT_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_VERT   = 2'd3;

  typedef struct packed {
    logic start;
    logic is_div;
  } sd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [CIW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 35'sd843314857;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043837;
      5'd3:    v = 35'sd133525159;
      5'd4:    v = 35'sd67021687;
      5'd5:    v = 35'sd33543516;
      5'd6:    v = 35'sd16775851;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194283;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048576;
      5'd11:   v = 35'sd524288;
      5'd12:   v = 35'sd262144;
      5'd13:   v = 35'sd131072;
      5'd14:   v = 35'sd65536;
      5'd15:   v = 35'sd32768;
      5'd16:   v = 35'sd16384;
      5'd17:   v = 35'sd8192;
      5'd18:   v = 35'sd4096;
      5'd19:   v = 35'sd2048;
      5'd20:   v = 35'sd1024;
      5'd21:   v = 35'sd512;
      5'd22:   v = 35'sd256;
      5'd23:   v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // shift right, round to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rsh_away(input logic signed [PW-1:0] v,
                                                     input int n);
    logic signed [PW-1:0] mag;
    logic signed [PW-1:0] q;
    mag = v[PW-1] ? -v : v;
    q = (mag + (PW'(1) << (n - 1))) >> n;
    return v[PW-1] ? -q : q;
  endfunction

  function automatic logic signed [15:0] q14_clamp(input logic signed [PW-1:0] v);
    logic signed [15:0] r;
    if (v > PW'(ONE_Q14)) r = 16'(ONE_Q14);
    else if (v < -PW'(ONE_Q14)) r = -16'(ONE_Q14);
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/fly_camera_update_unit.sv
// Top level of the fly camera update unit: sequencer, shared multiplier and camera state.
//
// One input transaction is one frame: mouse deltas, key flags and frame time.
// in_ready is high only while the sequencer is idle; a transaction is taken
// when in_valid and in_ready are both high. Each frame gives exactly one result
// transaction with the updated position and the forward, right and up vectors.
// A frame without net movement skips the square root and the divisions.
// The time from acceptance to out_valid of a frame is set by the CORDIC
// (one micro-rotation a cycle, run once for yaw and once for pitch), the
// square root (one result bit a cycle) and three divisions for the direction
// (one quotient bit a cycle), all sequenced around one 33x33 multiplier.
// The result sits in an output register; the next frame can be accepted while
// it waits. If the receiver stalls, the block finishes the next frame and then
// holds until the pending result is taken. Reset (rst_n low at a clock edge)
// zeroes yaw, pitch and position and loads the default register values. Configuration
// writes use cfg_we/cfg_index/cfg_wdata; the user writes only while idle (not enforced).
`default_nettype none
module fly_camera_update_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [fcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [15:0]                in_mouse_dx,
  input  wire logic signed [15:0]                in_mouse_dy,
  input  wire logic                              in_key_forward,
  input  wire logic                              in_key_back,
  input  wire logic                              in_key_strafe_right,
  input  wire logic                              in_key_strafe_left,
  input  wire logic                              in_key_rise,
  input  wire logic                              in_key_sprint,
  input  wire logic [15:0]                       in_frame_time,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [31:0]                     out_pos_x,
  output logic signed [31:0]                     out_pos_y,
  output logic signed [31:0]                     out_pos_z,
  output logic signed [15:0]                     out_fwd_x,
  output logic signed [15:0]                     out_fwd_y,
  output logic signed [15:0]                     out_fwd_z,
  output logic signed [15:0]                     out_rgt_x,
  output logic signed [15:0]                     out_rgt_y,
  output logic signed [15:0]                     out_rgt_z,
  output logic signed [15:0]                     out_upv_x,
  output logic signed [15:0]                     out_upv_y,
  output logic signed [15:0]                     out_upv_z
);
  import fcu_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_MX   = 5'd1,  S_MY   = 5'd2,  S_ANG  = 5'd3;
  localparam logic [4:0] S_CY   = 5'd4,  S_CP   = 5'd5,  S_B0   = 5'd6,  S_B1   = 5'd7;
  localparam logic [4:0] S_B2   = 5'd8,  S_B3   = 5'd9,  S_B4   = 5'd10, S_M    = 5'd11;
  localparam logic [4:0] S_SQ0  = 5'd12, S_SQ1  = 5'd13, S_SQ2  = 5'd14, S_SQ3  = 5'd15;
  localparam logic [4:0] S_S28  = 5'd16, S_SQRT = 5'd17, S_SQW  = 5'd18, S_DIV  = 5'd19;
  localparam logic [4:0] S_DIVW = 5'd20, S_D0   = 5'd21, S_D1   = 5'd22, S_D2   = 5'd23;
  localparam logic [4:0] S_FIN  = 5'd24;

  logic [4:0] state_r, state_nxt;

  logic [15:0] move_speed_r, look_gain_r;
  logic [7:0]  sprint_factor_r;
  logic        invert_vertical_r;

  logic signed [15:0] dx_r, dy_r;
  logic [15:0]        ft_r;
  logic               kf_r, kb_r, kr_r, kl_r, ku_r, ks_r;

  logic signed [ANG_W-1:0] heading_r, heading_nxt, elevation_r, elevation_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [XW-1:0]    cy_r, sy_r, cp_r, sp_r;
  logic signed [15:0]      fx_r, fy_r, fz_r, rx_r, rz_r, ux_r, uy_r, uz_r;
  logic signed [MVW-1:0]   m_r [3];
  logic [SSW-1:0]          ss_r;
  logic [S28W-1:0]         s28_r;
  logic [LENW-1:0]         len8_r;
  logic signed [DIRW-1:0]  dir_r;
  logic signed [PW-1:0]    lo_r;
  logic [1:0]              k_r;
  logic signed [POSW-1:0]  pos_r [3];

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p, p_r;

  logic                 cor_start;
  logic signed [ZW-1:0] cor_z;
  unit_stat_t           cor_stat;
  logic signed [XW-1:0] cor_c, cor_s;

  sd_cmd_t         sd_cmd;
  logic [SDW-1:0]  sd_a;
  unit_stat_t      sd_stat;
  logic [LENW-1:0] sd_q;

  logic signed [SUM_W-1:0] dyaw, dpit, h_sum, e_sum;
  logic signed [ZW-1:0]    y30;
  logic signed [MVW-1:0]   m_k, m_abs;
  logic signed [PW-1:0]    d_full, d_rnd;
  logic signed [POSW+1:0]  pos_sum;
  logic signed [POSW-1:0]  pos_sat;
  logic                    move_zero;
  logic                    out_load;

  function automatic logic signed [SUM_W-1:0] look_clamp(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] v;
    logic signed [SUM_W-1:0] r;
    v = rsh_away(p, LOOK_SHIFT);
    if (v > PW'(ANG_PI)) r = SUM_W'(ANG_PI);
    else if (v < -PW'(ANG_PI)) r = -SUM_W'(ANG_PI);
    else r = v[SUM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [MVW-1:0] key_term(input logic plus, input logic minus,
                                                     input logic signed [15:0] b);
    logic signed [MVW-1:0] t;
    t = '0;
    if (plus) t = t + MVW'(b);
    if (minus) t = t - MVW'(b);
    return t;
  endfunction

  fcu_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .z_in    (cor_z),
    .stat    (cor_stat),
    .cos_out (cor_c),
    .sin_out (cor_s)
  );

  fcu_sqdiv u_sqdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (sd_cmd),
    .a_in   (sd_a),
    .den_in (len8_r),
    .stat   (sd_stat),
    .q_out  (sd_q)
  );

  assign in_ready = (state_r == S_IDLE);
  assign mul_p    = mul_a * mul_b;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MX: begin
        mul_a = MW'(dx_r);
        mul_b = MW'(look_gain_r);
      end
      S_MY: begin
        mul_a = MW'(dy_r);
        mul_b = MW'(look_gain_r);
      end
      S_B0: begin
        mul_a = MW'(sy_r);
        mul_b = MW'(cp_r);
      end
      S_B1: begin
        mul_a = MW'(cy_r);
        mul_b = MW'(cp_r);
      end
      S_B2: begin
        mul_a = MW'(sp_r);
        mul_b = MW'(sy_r);
      end
      S_B3: begin
        mul_a = MW'(sp_r);
        mul_b = MW'(cy_r);
      end
      S_SQ0: begin
        mul_a = MW'(m_r[0]);
        mul_b = MW'(m_r[0]);
      end
      S_SQ1: begin
        mul_a = MW'(m_r[1]);
        mul_b = MW'(m_r[1]);
      end
      S_SQ2: begin
        mul_a = MW'(m_r[2]);
        mul_b = MW'(m_r[2]);
      end
      S_SQ3: begin
        mul_a = MW'(move_speed_r);
        mul_b = MW'(ft_r);
      end
      S_S28: begin
        mul_a = MW'(p_r[31:0]);
        mul_b = ks_r ? MW'(sprint_factor_r) : MW'(16);
      end
      S_D0: begin
        mul_a = MW'(dir_r);
        mul_b = MW'(s28_r[S28_SPLIT-1:0]);
      end
      S_D1: begin
        mul_a = MW'(dir_r);
        mul_b = MW'(s28_r[S28W-1:S28_SPLIT]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // angle update
  always_comb begin
    dyaw  = look_clamp(p_r);
    dpit  = invert_vertical_r ? -look_clamp(p_r) : look_clamp(p_r);
    h_sum = SUM_W'(heading_r) + dyaw;
    if (h_sum > SUM_W'(ANG_PI)) h_sum = h_sum - SUM_W'(2 * ANG_PI);
    else if (h_sum < -SUM_W'(ANG_PI)) h_sum = h_sum + SUM_W'(2 * ANG_PI);
    e_sum = SUM_W'(elevation_r) + dpit;
    if (e_sum > SUM_W'(ANG_LIMIT)) e_sum = SUM_W'(ANG_LIMIT);
    else if (e_sum < -SUM_W'(ANG_LIMIT)) e_sum = -SUM_W'(ANG_LIMIT);
    heading_nxt   = (state_r == S_MY) ? h_sum[ANG_W-1:0] : heading_r;
    elevation_nxt = (state_r == S_ANG) ? e_sum[ANG_W-1:0] : elevation_r;
    // yaw outside +-pi/2 is folded by pi
    y30     = ZW'(heading_r) <<< ANG_SHIFT;
    neg_nxt = neg_r;
    if (state_r == S_ANG) neg_nxt = 1'b0;
    if (y30 > ZW'(HALF_PI_Q30)) begin
      y30 = y30 - ZW'(PI_Q30);
      if (state_r == S_ANG) neg_nxt = 1'b1;
    end else if (y30 < -ZW'(HALF_PI_Q30)) begin
      y30 = y30 + ZW'(PI_Q30);
      if (state_r == S_ANG) neg_nxt = 1'b1;
    end
  end

  assign cor_start = (state_r == S_ANG) || ((state_r == S_CY) && cor_stat.done);
  assign cor_z     = (state_r == S_ANG) ? y30 : (ZW'(elevation_r) <<< ANG_SHIFT);

  assign m_k   = m_r[k_r];
  assign m_abs = m_k[MVW-1] ? -m_k : m_k;
  assign move_zero = (m_r[0] == '0) && (m_r[1] == '0) && (m_r[2] == '0);

  assign sd_cmd.start  = (state_r == S_SQRT) || (state_r == S_DIV);
  assign sd_cmd.is_div = (state_r == S_DIV);
  assign sd_a = (state_r == S_DIV) ?
                ((SDW'(m_abs) << DIR_SHIFT) + SDW'(len8_r >> 1)) :
                (SDW'(ss_r) << LEN_PRESHIFT);

  always_comb begin
    d_full  = (p_r <<< S28_SPLIT) + lo_r;
    d_rnd   = rsh_away(d_full, DISP_SHIFT);
    pos_sum = (POSW+2)'(pos_r[k_r]) + d_rnd[POSW+1:0];
    if (pos_sum > (POSW+2)'(64'sh7FFF_FFFF)) pos_sat = {1'b0, {(POSW-1){1'b1}}};
    else if (pos_sum < -(POSW+2)'(64'sh8000_0000)) pos_sat = {1'b1, {(POSW-1){1'b0}}};
    else pos_sat = pos_sum[POSW-1:0];
  end

  assign out_load = (state_r == S_FIN) && (!out_valid || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MX;
      S_MX:    state_nxt = S_MY;
      S_MY:    state_nxt = S_ANG;
      S_ANG:   state_nxt = S_CY;
      S_CY:    if (cor_stat.done) state_nxt = S_CP;
      S_CP:    if (cor_stat.done) state_nxt = S_B0;
      S_B0:    state_nxt = S_B1;
      S_B1:    state_nxt = S_B2;
      S_B2:    state_nxt = S_B3;
      S_B3:    state_nxt = S_B4;
      S_B4:    state_nxt = S_M;
      S_M:     state_nxt = S_SQ0;
      S_SQ0:   state_nxt = S_SQ1;
      S_SQ1:   state_nxt = S_SQ2;
      S_SQ2:   state_nxt = S_SQ3;
      S_SQ3:   state_nxt = move_zero ? S_FIN : S_S28;
      S_S28:   state_nxt = S_SQRT;
      S_SQRT:  state_nxt = S_SQW;
      S_SQW:   if (sd_stat.done) state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DIVW;
      S_DIVW:  if (sd_stat.done) state_nxt = S_D0;
      S_D0:    state_nxt = S_D1;
      S_D1:    state_nxt = S_D2;
      S_D2:    state_nxt = (k_r == 2'd2) ? S_FIN : S_DIV;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      move_speed_r      <= 16'd1280;
      sprint_factor_r   <= 8'd48;
      look_gain_r       <= 16'd131;
      invert_vertical_r <= 1'b0;
      heading_r         <= '0;
      elevation_r       <= '0;
      pos_r[0]          <= '0;
      pos_r[1]          <= '0;
      pos_r[2]          <= '0;
      out_valid         <= 1'b0;
      k_r               <= '0;
    end else begin
      state_r     <= state_nxt;
      heading_r   <= heading_nxt;
      elevation_r <= elevation_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MOVE_SPEED:    move_speed_r      <= cfg_wdata;
          REG_SPRINT_FACTOR: sprint_factor_r   <= cfg_wdata[7:0];
          REG_LOOK_GAIN:     look_gain_r       <= cfg_wdata;
          REG_INVERT_VERT:   invert_vertical_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_SQW) k_r <= '0;
      if (state_r == S_D2) begin
        pos_r[k_r] <= pos_sat;
        k_r        <= k_r + 1'b1;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_r   <= mul_p;
    neg_r <= neg_nxt;
    if (in_valid && in_ready) begin
      dx_r <= in_mouse_dx;
      dy_r <= in_mouse_dy;
      ft_r <= in_frame_time;
      kf_r <= in_key_forward;
      kb_r <= in_key_back;
      kr_r <= in_key_strafe_right;
      kl_r <= in_key_strafe_left;
      ku_r <= in_key_rise;
      ks_r <= in_key_sprint;
    end
    if ((state_r == S_CY) && cor_stat.done) begin
      cy_r <= neg_r ? -cor_c : cor_c;
      sy_r <= neg_r ? -cor_s : cor_s;
    end
    if ((state_r == S_CP) && cor_stat.done) begin
      cp_r <= cor_c;
      sp_r <= cor_s;
      fy_r <= q14_clamp(rsh_away(PW'(cor_s), SINGLE_SHIFT));
      uy_r <= q14_clamp(rsh_away(PW'(cor_c), SINGLE_SHIFT));
      rx_r <= q14_clamp(rsh_away(PW'(cy_r), SINGLE_SHIFT));
      rz_r <= q14_clamp(rsh_away(-PW'(sy_r), SINGLE_SHIFT));
    end
    case (state_r)
      S_B1: fx_r <= q14_clamp(rsh_away(p_r, PROD_SHIFT));
      S_B2: fz_r <= q14_clamp(rsh_away(p_r, PROD_SHIFT));
      S_B3: ux_r <= q14_clamp(rsh_away(-p_r, PROD_SHIFT));
      S_B4: uz_r <= q14_clamp(rsh_away(-p_r, PROD_SHIFT));
      S_M: begin
        m_r[0] <= key_term(kf_r, kb_r, fx_r) + key_term(kr_r, kl_r, rx_r);
        m_r[1] <= key_term(kf_r, kb_r, fy_r) + (ku_r ? MVW'(ONE_Q14) : MVW'(0));
        m_r[2] <= key_term(kf_r, kb_r, fz_r) + key_term(kr_r, kl_r, rz_r);
      end
      S_SQ1:  ss_r <= p_r[SSW-1:0];
      S_SQ2:  ss_r <= ss_r + p_r[SSW-1:0];
      S_SQ3:  ss_r <= ss_r + p_r[SSW-1:0];
      S_SQRT: s28_r <= p_r[S28W-1:0];
      S_D1:   lo_r <= p_r;
      default: ;
    endcase
    if ((state_r == S_SQW) && sd_stat.done) len8_r <= sd_q;
    if ((state_r == S_DIVW) && sd_stat.done)
      dir_r <= m_k[MVW-1] ? -DIRW'(sd_q) : DIRW'(sd_q);
    if (out_load) begin
      out_pos_x <= pos_r[0];
      out_pos_y <= pos_r[1];
      out_pos_z <= pos_r[2];
      out_fwd_x <= fx_r;
      out_fwd_y <= fy_r;
      out_fwd_z <= fz_r;
      out_rgt_x <= rx_r;
      out_rgt_z <= rz_r;
      out_upv_x <= ux_r;
      out_upv_y <= uy_r;
      out_upv_z <= uz_r;
    end
  end

  assign out_rgt_y = '0;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r <= ANG_W'(ANG_PI)) && (heading_r >= -ANG_W'(ANG_PI)))
    else $error("heading out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (elevation_r <= ANG_W'(ANG_LIMIT)) && (elevation_r >= -ANG_W'(ANG_LIMIT)))
    else $error("pitch beyond limit");

  a_cordic_alive: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CY) || (state_r == S_CP)) |-> (cor_stat.busy || cor_stat.done))
    else $error("waiting on idle cordic");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (len8_r != '0) && !move_zero)
    else $error("division by zero length");

endmodule
`default_nettype wire

// File: sv/fcu_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`default_nettype none
module fcu_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [fcu_pkg::ZW-1:0] z_in,
  output fcu_pkg::unit_stat_t                stat,
  output logic signed [fcu_pkg::XW-1:0]      cos_out,
  output logic signed [fcu_pkg::XW-1:0]      sin_out
);
  import fcu_pkg::*;

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [CIW-1:0]       cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = atan_q30(cnt_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = XW'(KGAIN_Q30);
      y_nxt    = '0;
      z_nxt    = z_in;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      if (cnt_r == CIW'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign cos_out   = x_r;
  assign sin_out   = y_r;

endmodule
`default_nettype wire

// File: sv/fcu_sqdiv.sv
// Shared shift-subtract unit: integer square root or restoring division, one bit per cycle.
`default_nettype none
module fcu_sqdiv (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fcu_pkg::sd_cmd_t             cmd,
  input  wire logic [fcu_pkg::SDW-1:0]      a_in,
  input  wire logic [fcu_pkg::LENW-1:0]     den_in,
  output fcu_pkg::unit_stat_t               stat,
  output logic [fcu_pkg::LENW-1:0]          q_out
);
  import fcu_pkg::*;

  logic [SDW-1:0]  acc_r, acc_nxt, aux_r, aux_nxt;
  logic [LENW-1:0] den_r, den_nxt;
  logic [SDCW-1:0] cnt_r, cnt_nxt;
  logic            is_div_r, is_div_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [SDW-1:0]  bit_sq, trial;
  logic            ge;

  assign bit_sq = SDW'(1) << {cnt_r, 1'b0};
  assign trial  = is_div_r ? (SDW'(den_r) << cnt_r) : (aux_r + bit_sq);
  assign ge     = acc_r >= trial;

  always_comb begin
    acc_nxt    = acc_r;
    aux_nxt    = aux_r;
    den_nxt    = den_r;
    cnt_nxt    = cnt_r;
    is_div_nxt = is_div_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (cmd.start) begin
      acc_nxt    = a_in;
      aux_nxt    = '0;
      den_nxt    = den_in;
      is_div_nxt = cmd.is_div;
      cnt_nxt    = cmd.is_div ? SDCW'(DIRW - 2) : SDCW'(SDW / 2 - 1);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (ge) acc_nxt = acc_r - trial;
      if (is_div_r) aux_nxt = ge ? (aux_r | (SDW'(1) << cnt_r)) : aux_r;
      else aux_nxt = ge ? ((aux_r >> 1) + bit_sq) : (aux_r >> 1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r    <= acc_nxt;
    aux_r    <= aux_nxt;
    den_r    <= den_nxt;
    cnt_r    <= cnt_nxt;
    is_div_r <= is_div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign q_out     = aux_r[LENW-1:0];

endmodule
`default_nettype wire
